// ----- sv/tmma_pkg.sv -----
`default_nettype none
package tmma_pkg;

    localparam int MAX_DIM = 64;
    localparam int NCELL   = 4;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int CELL_W  = $clog2(NCELL);
    localparam int CB_W    = DIM_W - CELL_W;
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int BADDR_W = DIM_W + CB_W;
    localparam int BDEPTH  = MAX_DIM * MAX_DIM / NCELL;
    localparam int SIZE_W  = 7;
    localparam int EL_W    = 16;
    localparam int ACC_W   = 40;
    localparam int IDX_W   = 6;

    typedef logic [2:0] t_op;
    localparam t_op OP_WR_A = 3'd0;
    localparam t_op OP_WR_B = 3'd1;
    localparam t_op OP_WR_C = 3'd2;
    localparam t_op OP_COMP = 3'd3;
    localparam t_op OP_RD_C = 3'd4;

    typedef struct packed {
        t_op                      opcode;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [EL_W-1:0]   element_value;
        logic signed [ACC_W-1:0]  accum_value;
    } t_in;

    typedef struct packed {
        logic                     result_kind;
        logic signed [ACC_W-1:0]  result_value;
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
    } t_out;

    typedef struct packed {
        logic                     valid;
        logic signed [EL_W-1:0]   a;
        logic [DIM_W-1:0]         k;
    } t_tok;

    typedef struct packed {
        logic                     en;
        logic [CELL_W-1:0]        lane;
        logic [BADDR_W-1:0]       addr;
        logic [EL_W-1:0]          data;
    } t_bwr;

endpackage
`default_nettype wire

// ----- sv/tmma_cell.sv -----
`default_nettype none
module tmma_cell import tmma_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CELL_W-1:0]       i_lane,
    input  t_bwr                    i_bwr,
    input  t_tok                    i_tok,
    input  logic [CB_W-1:0]         i_cb,
    input  logic                    i_shift,
    input  logic signed [ACC_W-1:0] i_acc,
    output t_tok                    o_tok,
    output logic signed [ACC_W-1:0] o_acc
);

    logic [EL_W-1:0]          r_bmem [BDEPTH];
    logic signed [EL_W-1:0]   r_bq;
    t_tok                     r_tok;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [2*EL_W-1:0] w_prod;

    // column slice of b for this lane
    always_ff @(posedge i_clk) begin
        if (i_bwr.en && i_bwr.lane == i_lane) begin
            r_bmem[i_bwr.addr] <= i_bwr.data;
        end
        r_bq <= r_bmem[{i_tok.k, i_cb}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    assign w_prod = r_tok.a * r_bq;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_acc <= i_acc;
        end else if (r_tok.valid) begin
            r_acc <= r_acc + ACC_W'(w_prod);
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule
`default_nettype wire

// ----- sv/tmma_array.sv -----
`default_nettype none
module tmma_array import tmma_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_bwr                    i_bwr,
    input  t_tok                    i_tok,
    input  logic [CB_W-1:0]         i_cb,
    input  logic                    i_shift,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic                    o_last_valid,
    output logic signed [ACC_W-1:0] o_acc
);

    t_tok                    w_tok [NCELL+1];
    logic signed [ACC_W-1:0] w_acc [NCELL+1];

    assign w_tok[0] = i_tok;
    assign w_acc[0] = i_acc;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        tmma_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (CELL_W'(i)),
            .i_bwr   (i_bwr),
            .i_tok   (w_tok[i]),
            .i_cb    (i_cb),
            .i_shift (i_shift),
            .i_acc   (w_acc[i]),
            .o_tok   (w_tok[i+1]),
            .o_acc   (w_acc[i+1])
        );
    end

    assign o_last_valid = w_tok[NCELL].valid;
    assign o_acc        = w_acc[NCELL];

endmodule
`default_nettype wire

// ----- sv/tiled_matrix_multiply_accumulate_top.sv -----
`default_nettype none
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_in  (t_in)
// out       output     o_out_valid / i_out_stall  o_out (t_out)
// cfg       input      i_cfg_we                   i_cfg_data (matrix_size)
//
// loads and reads take one item per cycle unless stalled; read data goes via r_cq to r_out
// compute walks rows and blocks of 4 columns through a chain of 4 mac cells,
//   one product per cell per cycle, with the input stalled
// after reset c is cleared one entry per cycle, all 4096 entries, with the input stalled
// a waiting result does not hold off loads; a blocked second result stalls the input
module tiled_matrix_multiply_accumulate_top import tmma_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_MAC, S_DRAIN, S_STORE, S_DONE
    } t_state;

    localparam int DRAIN_CYC = NCELL + 3;
    localparam int CNT_W     = $clog2(DRAIN_CYC + 1);

    t_state                  r_state;
    logic [ADDR_W-1:0]       r_clr;
    logic [SIZE_W-1:0]       r_size;
    logic [SIZE_W-1:0]       r_n;
    logic [DIM_W-1:0]        r_row;
    logic [CB_W-1:0]         r_cb;
    logic [DIM_W-1:0]        r_k;
    logic [CELL_W-1:0]       r_j;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_av;
    logic [DIM_W-1:0]        r_ak;
    logic signed [EL_W-1:0]  r_aq;
    logic                    r_ldv;
    logic signed [ACC_W-1:0] r_cq;
    logic                    r_p1_v;
    logic                    r_p1_kind;
    logic                    r_p1_in;
    logic [IDX_W-1:0]        r_p1_row;
    logic [IDX_W-1:0]        r_p1_col;
    logic                    r_out_v;
    t_out                    r_out;

    logic [EL_W-1:0]         r_amem [MAX_DIM*MAX_DIM];
    logic [ACC_W-1:0]        r_cmem [MAX_DIM*MAX_DIM];

    logic                    w_acc;
    logic                    w_move;
    logic                    w_inside;
    logic [ADDR_W-1:0]       w_in_addr;
    logic [SIZE_W-1:0]       w_nsat;
    logic [CELL_W-1:0]       w_lane;
    logic                    w_col_ok;
    logic                    w_last_cb;
    logic                    w_cwe;
    logic [ADDR_W-1:0]       w_cwa;
    logic [ACC_W-1:0]        w_cwd;
    logic                    w_cre;
    logic [ADDR_W-1:0]       w_cra;
    t_bwr                    w_bwr;
    t_tok                    w_tok;
    logic                    w_last_valid;
    logic signed [ACC_W-1:0] w_chain_acc;

    assign o_in_stall = (r_state != S_IDLE) || (r_p1_v && r_out_v && i_out_stall);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_move     = r_p1_v && (!r_out_v || !i_out_stall);

    assign w_inside  = (32'(i_in.row_index) < MAX_DIM) && (32'(i_in.col_index) < MAX_DIM);
    assign w_in_addr = {i_in.row_index[DIM_W-1:0], i_in.col_index[DIM_W-1:0]};
    assign w_nsat    = (32'(r_size) > MAX_DIM) ? SIZE_W'(MAX_DIM) : r_size;

    assign w_lane    = CELL_W'(NCELL - 1) - r_j;
    assign w_col_ok  = {1'b0, r_cb, w_lane} < r_n;
    assign w_last_cb = (32'({r_cb, CELL_W'(0)}) + NCELL) >= 32'(r_n);

    always_comb begin
        w_cwe = 1'b0;
        w_cwa = {r_row, r_cb, w_lane};
        w_cwd = w_chain_acc;
        if (r_state == S_CLEAR) begin
            w_cwe = 1'b1;
            w_cwa = r_clr;
            w_cwd = '0;
        end else if (r_state == S_STORE) begin
            w_cwe = w_col_ok;
        end else if (w_acc && i_in.opcode == OP_WR_C && w_inside) begin
            w_cwe = 1'b1;
            w_cwa = w_in_addr;
            w_cwd = i_in.accum_value;
        end
    end

    assign w_cre = (r_state == S_LOAD) || (w_acc && i_in.opcode == OP_RD_C);
    assign w_cra = (r_state == S_LOAD) ? {r_row, r_cb, w_lane} : w_in_addr;

    always_ff @(posedge i_clk) begin
        if (w_cwe) begin
            r_cmem[w_cwa] <= w_cwd;
        end
        if (w_cre) begin
            r_cq <= r_cmem[w_cra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.opcode == OP_WR_A && w_inside) begin
            r_amem[w_in_addr] <= i_in.element_value;
        end
        r_aq <= r_amem[{r_row, r_k}];
    end

    assign w_bwr.en   = w_acc && i_in.opcode == OP_WR_B && w_inside;
    assign w_bwr.lane = i_in.col_index[CELL_W-1:0];
    assign w_bwr.addr = {i_in.row_index[DIM_W-1:0], i_in.col_index[DIM_W-1:CELL_W]};
    assign w_bwr.data = i_in.element_value;

    assign w_tok.valid = r_av;
    assign w_tok.a     = r_aq;
    assign w_tok.k     = r_ak;

    tmma_array u_array (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bwr        (w_bwr),
        .i_tok        (w_tok),
        .i_cb         (r_cb),
        .i_shift      (r_ldv || r_state == S_STORE),
        .i_acc        (r_cq),
        .o_last_valid (w_last_valid),
        .o_acc        (w_chain_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_size  <= SIZE_W'(64);
            r_p1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_av    <= 1'b0;
            r_ldv   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            r_av  <= (r_state == S_MAC);
            r_ldv <= (r_state == S_LOAD);

            if (w_move) begin
                r_out_v              <= 1'b1;
                r_out.result_kind    <= r_p1_kind;
                r_out.result_value   <= (r_p1_kind && r_p1_in) ? r_cq : '0;
                r_out.out_row        <= r_p1_row;
                r_out.out_col        <= r_p1_col;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end

            if (w_acc && i_in.opcode == OP_RD_C) begin
                r_p1_v    <= 1'b1;
                r_p1_kind <= 1'b1;
                r_p1_in   <= w_inside;
                r_p1_row  <= i_in.row_index;
                r_p1_col  <= i_in.col_index;
            end else if (w_move) begin
                r_p1_v <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc && i_in.opcode == OP_COMP) begin
                        r_n   <= w_nsat;
                        r_row <= '0;
                        r_cb  <= '0;
                        r_j   <= '0;
                        if (w_nsat == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == CELL_W'(NCELL - 1)) begin
                        r_k     <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_ak <= r_k;
                    r_k  <= r_k + 1'b1;
                    if ({1'b0, r_k} == r_n - 1'b1) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_cnt != CNT_W'(DRAIN_CYC)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!w_last_valid) begin
                        r_j     <= '0;
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == CELL_W'(NCELL - 1)) begin
                        if (w_last_cb) begin
                            r_cb <= '0;
                            if ({1'b0, r_row} == r_n - 1'b1) begin
                                r_state <= S_DONE;
                            end else begin
                                r_row   <= r_row + 1'b1;
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_cb    <= r_cb + 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_p1_v) begin
                        r_p1_v    <= 1'b1;
                        r_p1_kind <= 1'b0;
                        r_p1_in   <= 1'b0;
                        r_p1_row  <= '0;
                        r_p1_col  <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule
`default_nettype wire
